// File: hdl/assert_macros.svh
// Assertion macros shared by the projector RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted
`define TPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication form of the same check
`define TPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hdl/tpc_pkg.sv
// Types and constants of the transverse projector coefficient block
`default_nettype none
package tpc_pkg;

  localparam int MAX_GRID   = 256;
  localparam int FRAC_BITS  = 16;
  localparam int GRID_W     = 9;
  localparam int IDX_W      = 8;
  localparam int SQ_W       = 16;
  localparam int STRIDE_W   = 16;
  localparam int POS_W      = 24;
  localparam int PROJ_W     = 18;
  localparam int QUO_W      = FRAC_BITS + 1;
  localparam int DIV_W      = 17;
  localparam int DIV_STEPS  = QUO_W;
  localparam int LANES      = 6;
  localparam int MID_DEPTH  = 8;
  localparam int OUT_DEPTH  = 32;
  localparam int GRID_RESET = 64;

  localparam int LANE_XX = 0;
  localparam int LANE_XY = 1;
  localparam int LANE_XZ = 2;
  localparam int LANE_YY = 3;
  localparam int LANE_YZ = 4;
  localparam int LANE_ZZ = 5;

  localparam logic signed [PROJ_W-1:0] PROJ_ONE = PROJ_W'(1 << FRAC_BITS);

  typedef struct packed {
    logic [GRID_W-1:0]   n;
    logic [IDX_W-1:0]    hp1;
    logic [STRIDE_W-1:0] stride;
  } grid_cfg_t;

  typedef struct packed {
    logic [SQ_W-1:0]             sum;
    logic [LANES-1:0][SQ_W-1:0]  mag;
    logic [LANES-1:0]            neg;
    logic [POS_W-1:0]            pos;
    logic                        zero;
  } front_item_t;

  typedef struct packed {
    logic [LANES-1:0][DIV_W-1:0] rem;
    logic [LANES-1:0][QUO_W-1:0] quo;
    logic [DIV_W-1:0]            dsr;
    logic [DIV_W-1:0]            low;
    logic [LANES-1:0]            neg;
    logic [POS_W-1:0]            pos;
    logic                        zero;
  } div_stage_t;

  typedef struct packed {
    logic [LANES-1:0][PROJ_W-1:0] proj;
    logic [POS_W-1:0]             pos;
    logic                         zero;
  } result_t;

  // Clamp, force even and derive the row strides of the half spectrum
  function automatic grid_cfg_t grid_cfg(input logic [GRID_W-1:0] w);
    logic [GRID_W-1:0] n;
    logic [17:0]       prod;
    grid_cfg_t         c;
    n = w;
    if (n < GRID_W'(2)) n = GRID_W'(2);
    if (n > GRID_W'(MAX_GRID)) n = GRID_W'(MAX_GRID);
    n[0]     = 1'b0;
    c.n      = n;
    c.hp1    = n[GRID_W-1:1] + IDX_W'(1);
    prod     = 18'(n) * 18'(c.hp1);
    c.stride = prod[STRIDE_W-1:0];
    return c;
  endfunction

endpackage
`default_nettype wire

// File: hdl/tpc_fifo.sv
// Register queue with a combinational head read
`default_nettype none
`include "assert_macros.svh"
module tpc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? wr_q + PW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + PW'(1) : rd_q;
    cnt_d = cnt_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);

  `TPC_ASSERT_IMP(a_no_overflow, push_i, cnt_q < CW'(DEPTH), "queue written while full")
  `TPC_ASSERT_IMP(a_no_underflow, pop_i, cnt_q != '0, "queue read while empty")
  `TPC_ASSERT(a_cnt_bound, cnt_q <= CW'(DEPTH), "queue count beyond depth")

endmodule
`default_nettype wire

// File: hdl/tpc_front.sv
// Front end: index clamping, folding, squares and half-spectrum position
`default_nettype none
module tpc_front
  import tpc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire logic [IDX_W-1:0] index_x_i,
  input  wire logic [IDX_W-1:0] index_y_i,
  input  wire logic [IDX_W-1:0] index_z_i,
  input  wire grid_cfg_t        cfg_i,
  output logic                  valid_o,
  output front_item_t           item_o
);
  logic [IDX_W-1:0]  half, a_sat, b_sat, c_sat, ma, mb;
  logic [GRID_W-1:0] nm1, ma_w, mb_w;
  logic              na, nb;

  logic              v1_q, v2_q, v3_q;
  logic [IDX_W-1:0]  ma_q, mb_q, mc_q, a_q, b_q, c_q;
  logic              na_q, nb_q, na2_q, nb2_q;
  logic [SQ_W-1:0]   sq_a_q, sq_b_q, sq_c_q, p_ab_q, p_ac_q, p_bc_q;
  logic [POS_W-1:0]  pos_a_q;
  logic [SQ_W-1:0]   pos_b_q;
  logic [IDX_W-1:0]  c2_q;
  logic [SQ_W+1:0]   sum_w;
  logic [SQ_W-1:0]   sum;
  front_item_t       item_d, item_q;

  // Clamp out-of-range indices and fold the upper half to negative wave numbers
  always_comb begin
    half  = cfg_i.n[GRID_W-1:1];
    nm1   = cfg_i.n - GRID_W'(1);
    a_sat = ({1'b0, index_x_i} >= cfg_i.n) ? nm1[IDX_W-1:0] : index_x_i;
    b_sat = ({1'b0, index_y_i} >= cfg_i.n) ? nm1[IDX_W-1:0] : index_y_i;
    c_sat = (index_z_i > half) ? half : index_z_i;
    na    = a_sat > half;
    nb    = b_sat > half;
    ma_w  = cfg_i.n - {1'b0, a_sat};
    mb_w  = cfg_i.n - {1'b0, b_sat};
    ma    = na ? ma_w[IDX_W-1:0] : a_sat;
    mb    = nb ? mb_w[IDX_W-1:0] : b_sat;
  end

  always_comb begin
    sum_w = 18'(sq_a_q) + 18'(sq_b_q) + 18'(sq_c_q);
    sum   = sum_w[SQ_W-1:0];
    item_d.sum           = sum;
    item_d.mag[LANE_XX]  = sum - sq_a_q;
    item_d.mag[LANE_YY]  = sum - sq_b_q;
    item_d.mag[LANE_ZZ]  = sum - sq_c_q;
    item_d.mag[LANE_XY]  = p_ab_q;
    item_d.mag[LANE_XZ]  = p_ac_q;
    item_d.mag[LANE_YZ]  = p_bc_q;
    item_d.neg           = '0;
    item_d.neg[LANE_XY]  = (p_ab_q != '0) && (na2_q == nb2_q);
    item_d.neg[LANE_XZ]  = (p_ac_q != '0) && !na2_q;
    item_d.neg[LANE_YZ]  = (p_bc_q != '0) && !nb2_q;
    item_d.pos           = pos_a_q + POS_W'(pos_b_q) + POS_W'(c2_q);
    item_d.zero          = (sum == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q    <= ma;
    mb_q    <= mb;
    mc_q    <= c_sat;
    na_q    <= na;
    nb_q    <= nb;
    a_q     <= a_sat;
    b_q     <= b_sat;
    c_q     <= c_sat;
    sq_a_q  <= SQ_W'(ma_q) * SQ_W'(ma_q);
    sq_b_q  <= SQ_W'(mb_q) * SQ_W'(mb_q);
    sq_c_q  <= SQ_W'(mc_q) * SQ_W'(mc_q);
    p_ab_q  <= SQ_W'(ma_q) * SQ_W'(mb_q);
    p_ac_q  <= SQ_W'(ma_q) * SQ_W'(mc_q);
    p_bc_q  <= SQ_W'(mb_q) * SQ_W'(mc_q);
    pos_a_q <= POS_W'(a_q) * POS_W'(cfg_i.stride);
    pos_b_q <= SQ_W'(b_q) * SQ_W'(cfg_i.hp1);
    c2_q    <= c_q;
    na2_q   <= na_q;
    nb2_q   <= nb_q;
    item_q  <= item_d;
  end

  assign valid_o = v3_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

// File: hdl/tpc_back.sv
// Back end: six-lane restoring divider, one quotient bit per stage
`default_nettype none
module tpc_back
  import tpc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire front_item_t item_i,
  output logic             valid_o,
  output result_t          res_o
);
  div_stage_t             st_in [DIV_STEPS];
  div_stage_t             st_nx [DIV_STEPS];
  div_stage_t             st_q  [DIV_STEPS];
  logic [DIV_STEPS-1:0]   v_q;
  div_stage_t             init;

  // Dividend is mag * 2^(F+1) + s, divisor 2s: rounds to nearest, ties up
  always_comb begin
    init.dsr  = {item_i.sum, 1'b0};
    init.low  = DIV_W'(item_i.sum);
    init.neg  = item_i.neg;
    init.pos  = item_i.pos;
    init.zero = item_i.zero;
    init.quo  = '0;
    for (int l = 0; l < LANES; l++) begin
      init.rem[l] = DIV_W'(item_i.mag[l]);
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    if (k == 0) begin : g_first
      assign st_in[k] = init;
    end else begin : g_next
      assign st_in[k] = st_q[k-1];
    end

    always_comb begin
      logic [DIV_W:0] r2;
      logic           ge;
      st_nx[k] = st_in[k];
      for (int l = 0; l < LANES; l++) begin
        r2 = {st_in[k].rem[l], st_in[k].low[DIV_W-1-k]};
        ge = r2 >= {1'b0, st_in[k].dsr};
        r2 = ge ? r2 - {1'b0, st_in[k].dsr} : r2;
        st_nx[k].rem[l] = r2[DIV_W-1:0];
        st_nx[k].quo[l] = {st_in[k].quo[l][QUO_W-2:0], ge};
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[k] <= st_nx[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[DIV_STEPS-2:0], valid_i};
    end
  end

  // Apply signs; the zero mode gives the identity
  always_comb begin
    logic [PROJ_W-1:0] q;
    for (int l = 0; l < LANES; l++) begin
      q = PROJ_W'(st_q[DIV_STEPS-1].quo[l]);
      res_o.proj[l] = st_q[DIV_STEPS-1].neg[l] ? -q : q;
    end
    if (st_q[DIV_STEPS-1].zero) begin
      res_o.proj          = '0;
      res_o.proj[LANE_XX] = PROJ_ONE;
      res_o.proj[LANE_YY] = PROJ_ONE;
      res_o.proj[LANE_ZZ] = PROJ_ONE;
    end
    res_o.pos  = st_q[DIV_STEPS-1].pos;
    res_o.zero = st_q[DIV_STEPS-1].zero;
  end

  assign valid_o = v_q[DIV_STEPS-1];

endmodule
`default_nettype wire

// File: hdl/transverse_projector_coefficients_top.sv
// Path: front end, middle queue, divider pipeline, then the output queue head.
// Throughput: one item per cycle while not full and the output queue has room;
// the 32-entry output queue bounds the items in the 17-stage divider pipeline.
// Reset: asynchronous, active low; empties all queues, grid size returns to 64.
// Push is refused only while the 8 credits of the middle queue are used.
`default_nettype none
`include "assert_macros.svh"
module transverse_projector_coefficients_top
  import tpc_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic [IDX_W-1:0]         index_x_i,
  input  wire logic [IDX_W-1:0]         index_y_i,
  input  wire logic [IDX_W-1:0]         index_z_i,
  output logic                          empty,
  input  wire logic                     pop,
  output logic signed [PROJ_W-1:0]      proj_xx_o,
  output logic signed [PROJ_W-1:0]      proj_xy_o,
  output logic signed [PROJ_W-1:0]      proj_xz_o,
  output logic signed [PROJ_W-1:0]      proj_yy_o,
  output logic signed [PROJ_W-1:0]      proj_yz_o,
  output logic signed [PROJ_W-1:0]      proj_zz_o,
  output logic [POS_W-1:0]              spectrum_position_o,
  output logic                          zero_mode_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [GRID_W-1:0]        cfg_wdata_i
);
  localparam int MCW = $clog2(MID_DEPTH + 1);
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  grid_cfg_t        cfg_q;
  logic [MCW-1:0]   front_cnt_q, front_cnt_d;
  logic [OCW-1:0]   out_cnt_q, out_cnt_d;
  logic             in_xfer, out_xfer, mid_pop, mid_empty;
  logic             front_valid, back_valid;
  front_item_t      front_item, mid_item;
  result_t          back_res, out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= grid_cfg(GRID_W'(GRID_RESET));
    end else if (cfg_we_i) begin
      cfg_q <= grid_cfg(cfg_wdata_i);
    end
  end

  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;
  // Issue to the divider only with a free slot in the output queue
  assign mid_pop  = !mid_empty && (out_cnt_q < OCW'(OUT_DEPTH));

  always_comb begin
    front_cnt_d = front_cnt_q + MCW'(in_xfer) - MCW'(mid_pop);
    out_cnt_d   = out_cnt_q + OCW'(mid_pop) - OCW'(out_xfer);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_cnt_q <= '0;
      out_cnt_q   <= '0;
    end else begin
      front_cnt_q <= front_cnt_d;
      out_cnt_q   <= out_cnt_d;
    end
  end

  assign full = (front_cnt_q == MCW'(MID_DEPTH));

  tpc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_xfer),
    .index_x_i (index_x_i),
    .index_y_i (index_y_i),
    .index_z_i (index_z_i),
    .cfg_i     (cfg_q),
    .valid_o   (front_valid),
    .item_o    (front_item)
  );

  tpc_fifo #(
    .WIDTH ($bits(front_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_item),
    .pop_i   (mid_pop),
    .data_o  (mid_item),
    .empty_o (mid_empty)
  );

  tpc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_pop),
    .item_i  (mid_item),
    .valid_o (back_valid),
    .res_o   (back_res)
  );

  tpc_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_valid),
    .data_i  (back_res),
    .pop_i   (out_xfer),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign proj_xx_o           = out_res.proj[LANE_XX];
  assign proj_xy_o           = out_res.proj[LANE_XY];
  assign proj_xz_o           = out_res.proj[LANE_XZ];
  assign proj_yy_o           = out_res.proj[LANE_YY];
  assign proj_yz_o           = out_res.proj[LANE_YZ];
  assign proj_zz_o           = out_res.proj[LANE_ZZ];
  assign spectrum_position_o = out_res.pos;
  assign zero_mode_o         = out_res.zero;

  `TPC_ASSERT(a_front_credit, front_cnt_q <= MCW'(MID_DEPTH), "front credits exceeded")
  `TPC_ASSERT(a_out_credit, out_cnt_q <= OCW'(OUT_DEPTH), "output credits exceeded")
  `TPC_ASSERT_IMP(a_zero_identity, !empty && zero_mode_o,
                  proj_xx_o == PROJ_ONE && proj_xy_o == '0, "zero mode not identity")

endmodule
`default_nettype wire
